// ===== src/assert_macros.svh =====
// assertion macros used by the rtl file gcode_word_lexer.sv
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_ALWAYS(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// consequence checked in the cycle after the trigger
`define ASSERT_NEXT(name, trig, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) else $error(msg);

`endif

// ===== src/gwl_pkg.sv =====
// types, character constants and classification for the g-code word lexer
package gwl_pkg;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_KEY   = 3'd1,
		ST_VALUE = 3'd2,
		ST_PARSE = 3'd3,
		ST_ERROR = 3'd4
	} lexer_state_t;

	typedef enum logic [2:0] {
		CL_E       = 3'd0,
		CL_LETTER  = 3'd1,
		CL_DIGIT   = 3'd2,
		CL_BLANK   = 3'd3,
		CL_INVALID = 3'd4
	} char_class_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_KEY      = 3'd1,
		EV_VALUE    = 3'd2,
		EV_WORD     = 3'd3,
		EV_GRAMMAR  = 3'd4,
		EV_TOO_LONG = 3'd5
	} lex_event_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_E  = 8'h45;
	localparam logic [7:0] CH_UP_Z  = 8'h5A;
	localparam logic [7:0] CH_LO_A  = 8'h61;
	localparam logic [7:0] CH_LO_E  = 8'h65;
	localparam logic [7:0] CH_LO_Z  = 8'h7A;
	localparam logic [7:0] CASE_OFFSET = 8'h20;

	// reset value of the length limit register
	localparam logic [5:0] LIMIT_RESET = 6'd32;

	// sort one character into its lexical class
	function automatic char_class_t classify(input logic [7:0] c);
		char_class_t cl;
		if (c == CH_LO_E || c == CH_UP_E) begin
			cl = CL_E;
		end else if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z)) begin
			cl = CL_LETTER;
		end else if ((c >= CH_ZERO && c <= CH_NINE) || c == CH_POINT
				|| c == CH_PLUS || c == CH_MINUS) begin
			cl = CL_DIGIT;
		end else if (c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR
				|| c == CH_NUL) begin
			cl = CL_BLANK;
		end else begin
			cl = CL_INVALID;
		end
		return cl;
	endfunction

	// line terminators
	function automatic logic is_eol(input logic [7:0] c);
		return (c == CH_LF || c == CH_CR || c == CH_NUL);
	endfunction

	// lower-case letters to upper case, everything else unchanged
	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= CH_LO_A && c <= CH_LO_Z) ? (c - CASE_OFFSET) : c;
	endfunction

endpackage

// ===== src/gcode_word_lexer.sv =====
// g-code word lexer: one character in, one lexer event out
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------------
//  char in   | ch_valid / ch_stall   | ch
//  event out | res_valid / res_stall | event_res key_letter value_char
//            |                       | value_length line_end block_valid
//  config    | cfg_valid / cfg_ready | max_value_length
//
// one character per cycle sustained while res_stall is low; path: input register, then result register
// the lexer state update is one small step of logic between those registers
// arst_n clears the lexer state and the pipeline valids and loads the limit with 32
// a stalled result holds in the result register; the input register keeps taking
// characters until it is full too, then ch_stall rises
`include "assert_macros.svh"

module gcode_word_lexer #(
	parameter int MAX_VALUE_LEN = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	// character channel
	input  logic       ch_valid,
	output logic       ch_stall,
	input  logic [7:0] ch,
	// result channel
	output logic       res_valid,
	input  logic       res_stall,
	output logic [2:0] event_res,
	output logic [7:0] key_letter,
	output logic [7:0] value_char,
	output logic [5:0] value_length,
	output logic       line_end,
	output logic       block_valid,
	// configuration channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [5:0] max_value_length
);

	localparam logic [5:0] MaxLen = 6'(MAX_VALUE_LEN);

	// input register
	logic       valid_s1;
	logic [7:0] ch_s1;

	// lexer state
	gwl_pkg::lexer_state_t state_q;
	gwl_pkg::lexer_state_t state_nxt;
	logic [7:0]            held_key_q;
	logic [5:0]            value_count_q;
	logic                  block_failed_q;
	logic [5:0]            limit_cfg_q;

	// step logic
	gwl_pkg::char_class_t cls;
	gwl_pkg::lex_event_t  ev;
	logic [5:0]           limit;
	logic                 eol;
	logic [7:0]           key_nxt;
	logic [5:0]           count_nxt;
	logic                 failed_nxt;
	logic [7:0]           vchar;
	logic [5:0]           vlen;

	// handshake control
	logic res_free;
	logic advance;

	assign res_free  = !res_valid || !res_stall;
	assign advance   = valid_s1 && res_free;
	assign ch_stall  = valid_s1 && !res_free;
	assign cfg_ready = 1'b1;

	// limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_cfg_q <= gwl_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			limit_cfg_q <= max_value_length;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!ch_stall) begin
			valid_s1 <= ch_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ch_valid && !ch_stall) begin
			ch_s1 <= ch;
		end
	end

	// classification and clamped limit
	assign cls   = gwl_pkg::classify(ch_s1);
	assign eol   = gwl_pkg::is_eol(ch_s1);
	assign limit = (limit_cfg_q > MaxLen) ? MaxLen : limit_cfg_q;

	// next state
	always_comb begin
		case (state_q)
			gwl_pkg::ST_IDLE, gwl_pkg::ST_PARSE: begin
				if (cls == gwl_pkg::CL_E || cls == gwl_pkg::CL_LETTER) begin
					state_nxt = gwl_pkg::ST_KEY;
				end else if (cls == gwl_pkg::CL_BLANK) begin
					state_nxt = gwl_pkg::ST_IDLE;
				end else begin
					state_nxt = gwl_pkg::ST_ERROR;
				end
			end
			gwl_pkg::ST_KEY: begin
				state_nxt = (cls == gwl_pkg::CL_DIGIT) ? gwl_pkg::ST_VALUE : gwl_pkg::ST_ERROR;
			end
			gwl_pkg::ST_VALUE: begin
				if (cls == gwl_pkg::CL_E || cls == gwl_pkg::CL_DIGIT) begin
					state_nxt = gwl_pkg::ST_VALUE;
				end else if (cls == gwl_pkg::CL_BLANK) begin
					state_nxt = gwl_pkg::ST_PARSE;
				end else begin
					state_nxt = gwl_pkg::ST_ERROR;
				end
			end
			default: begin
				state_nxt = gwl_pkg::ST_ERROR;
			end
		endcase
	end

	// event, key, count and failure flag for this character
	always_comb begin
		ev         = gwl_pkg::EV_NONE;
		key_nxt    = held_key_q;
		count_nxt  = value_count_q;
		failed_nxt = block_failed_q;
		vchar      = 8'd0;
		vlen       = value_count_q;
		case (state_nxt)
			gwl_pkg::ST_KEY: begin
				key_nxt = gwl_pkg::upcase(ch_s1);
				ev      = gwl_pkg::EV_KEY;
			end
			gwl_pkg::ST_VALUE: begin
				if (value_count_q < limit) begin
					count_nxt = value_count_q + 6'd1;
					vchar     = ch_s1;
					ev        = gwl_pkg::EV_VALUE;
				end else begin
					failed_nxt = 1'b1;
					ev         = gwl_pkg::EV_TOO_LONG;
				end
				vlen = count_nxt;
			end
			gwl_pkg::ST_PARSE: begin
				ev        = gwl_pkg::EV_WORD;
				count_nxt = 6'd0;
			end
			gwl_pkg::ST_ERROR: begin
				if (state_q != gwl_pkg::ST_ERROR) begin
					ev         = gwl_pkg::EV_GRAMMAR;
					failed_nxt = 1'b1;
				end
			end
			default: begin
				ev = gwl_pkg::EV_NONE;
			end
		endcase
	end

	// lexer state update, end of line returns to reset values
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= gwl_pkg::ST_IDLE;
			held_key_q     <= 8'd0;
			value_count_q  <= 6'd0;
			block_failed_q <= 1'b0;
		end else if (advance) begin
			if (eol) begin
				state_q        <= gwl_pkg::ST_IDLE;
				held_key_q     <= 8'd0;
				value_count_q  <= 6'd0;
				block_failed_q <= 1'b0;
			end else begin
				state_q        <= state_nxt;
				held_key_q     <= key_nxt;
				value_count_q  <= count_nxt;
				block_failed_q <= failed_nxt;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else if (res_free) begin
			res_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_res    <= ev;
			key_letter   <= key_nxt;
			value_char   <= vchar;
			value_length <= vlen;
			line_end     <= eol;
			block_valid  <= !failed_nxt;
		end
	end

	// checks
	`ASSERT_ALWAYS(a_count_in_range, value_count_q <= MaxLen, "value count above limit")
	`ASSERT_ALWAYS(a_stall_needs_full, !ch_stall || valid_s1, "stall with empty input register")
	`ASSERT_NEXT(a_eol_clears, advance && eol,
		state_q == gwl_pkg::ST_IDLE && value_count_q == 6'd0 && !block_failed_q,
		"end of line did not reset lexer")
	`ASSERT_NEXT(a_error_sticks, advance && !eol && state_q == gwl_pkg::ST_ERROR,
		state_q == gwl_pkg::ST_ERROR && block_failed_q, "error state left before end of line")

endmodule
